// ----- hw/rtl/fmp_pkg.sv -----
// fmp_pkg: shared constants, codes and types of the mirror-padded fir filter
// no dependencies; imported by the filter top level and its mac datapath
`timescale 1ns / 1ps
`default_nettype none

package fmp_pkg;

  localparam int unsigned MaxHalfTapsDef  = 63;
  localparam int unsigned SampleBitsDef   = 16;
  localparam int unsigned CoefFracBitsDef = 17;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  // control from the sequencer to the mac datapath
  typedef struct packed {
    logic coef_we;
    logic issue;
    logic clear;
  } mac_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fmp_in_if.sv -----
// fmp_in_if: input channel of the filter, one coefficient load or one sample per beat
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface fmp_in_if #(
  parameter int unsigned SampleBits = 16,
  parameter int unsigned CoefBits   = 18,
  parameter int unsigned TapAw      = 7
);
  logic                 valid;
  logic                 ready;
  logic                 operation;
  logic [TapAw-1:0]     coef_index;
  logic [CoefBits-1:0]  coef_value;
  logic [SampleBits-1:0] sample;
  logic                 last_sample;

  modport source (output valid, operation, coef_index, coef_value, sample, last_sample,
                  input ready);
  modport sink   (input valid, operation, coef_index, coef_value, sample, last_sample,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/fmp_out_if.sv -----
// fmp_out_if: result channel of the filter, one filtered value per beat
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface fmp_out_if #(
  parameter int unsigned SampleBits = 16
);
  logic                  valid;
  logic                  ready;
  logic [SampleBits-1:0] filtered_value;
  logic                  last_of_record;
  logic                  short_record;

  modport source (output valid, filtered_value, last_of_record, short_record, input ready);
  modport sink   (input valid, filtered_value, last_of_record, short_record, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/fmp_cfg_if.sv -----
// fmp_cfg_if: configuration write channel carrying the half_taps register
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface fmp_cfg_if #(
  parameter int unsigned HtW = 6
);
  logic           valid;
  logic           ready;
  logic [HtW-1:0] half_taps;

  modport source (output valid, half_taps, input ready);
  modport sink   (input valid, half_taps, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/fmp_mac.sv -----
// fmp_mac: coefficient memory, shared multiply-accumulate and round/saturate stage
// depends on fmp_pkg
`timescale 1ns / 1ps
`default_nettype none

module fmp_mac import fmp_pkg::*; #(
  parameter int unsigned SampleBits   = SampleBitsDef,
  parameter int unsigned CoefFracBits = CoefFracBitsDef,
  parameter int unsigned TapDepth     = 2 * MaxHalfTapsDef + 1,
  localparam int unsigned TapAw       = $clog2(TapDepth),
  localparam int unsigned CoefW       = CoefFracBits + 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mac_ctrl_t                    ctrl_i,
  input  logic [TapAw-1:0]             coef_waddr_i,
  input  logic signed [CoefW-1:0]      coef_wdata_i,
  input  logic [TapAw-1:0]             tap_i,
  input  logic signed [SampleBits-1:0] dly_rd_i,
  output logic                         busy_o,
  output logic [SampleBits-1:0]        result_o
);

  localparam int unsigned ProdW = SampleBits + CoefW;
  localparam int unsigned AccW  = ProdW + TapAw;
  localparam logic [AccW-1:0] Half = {{(AccW-1){1'b0}}, 1'b1} << (CoefFracBits - 1);
  localparam logic signed [AccW-1:0] SMax =
    signed'({{(AccW-SampleBits+1){1'b0}}, {(SampleBits-1){1'b1}}});
  localparam logic signed [AccW-1:0] SMin = ~SMax;

  logic signed [CoefW-1:0] coef_mem [TapDepth];
  logic signed [CoefW-1:0] coef_rd_q;
  logic                    v1_q, v2_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [AccW-1:0]  rnd, quo;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.coef_we) begin
      coef_mem[coef_waddr_i] <= coef_wdata_i;
    end
    if (ctrl_i.issue) begin
      coef_rd_q <= coef_mem[tap_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      acc_q <= '0;
    end else begin
      v1_q <= ctrl_i.issue;
      v2_q <= v1_q;
      if (ctrl_i.clear) begin
        acc_q <= '0;
      end else if (v2_q) begin
        acc_q <= acc_q + AccW'(prod_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      prod_q <= coef_rd_q * dly_rd_i;
    end
  end

  // round half up, floor shift, then clamp to the sample range
  always_comb begin
    rnd = acc_q + signed'(Half);
    quo = rnd >>> CoefFracBits;
    if (quo > SMax) begin
      result_o = SMax[SampleBits-1:0];
    end else if (quo < SMin) begin
      result_o = SMin[SampleBits-1:0];
    end else begin
      result_o = quo[SampleBits-1:0];
    end
  end

  assign busy_o = v1_q | v2_q;

endmodule

`default_nettype wire

// ----- hw/rtl/fir_filter_mirror_padded.sv -----
// fir_filter_mirror_padded: symmetric fir over a record with mirrored edges
// one shared mac walks 2*h+1 taps per output (h = half_taps); the sample that starts
// filtering first primes the delay line with 2*h mirrored held samples, and the last
// sample adds h flushed outputs; loads and held samples keep the filter idle, save a
// short record's last sample; not ready while an item is in work
// reset is asynchronous active low; memories need no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module fir_filter_mirror_padded import fmp_pkg::*; #(
  parameter int unsigned MaxHalfTaps  = MaxHalfTapsDef,
  parameter int unsigned SampleBits   = SampleBitsDef,
  parameter int unsigned CoefFracBits = CoefFracBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fmp_in_if.sink    in_i,
  fmp_out_if.source out_o,
  fmp_cfg_if.sink   cfg_i
);

  localparam int unsigned TapDepth = 2 * MaxHalfTaps + 1;
  localparam int unsigned TapAw    = $clog2(TapDepth);
  localparam int unsigned DlyDepth = 2 ** TapAw;
  localparam int unsigned HtW      = $clog2(MaxHalfTaps + 1);
  localparam int unsigned PosW     = HtW + 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PRIME_RD, ST_PRIME_WR, ST_PUSH, ST_MAC,
    ST_DRAIN, ST_EMIT, ST_FLUSH_RD, ST_FLUSH_LD, ST_SHORT
  } state_e;

  state_e                 state_q, state_d;
  logic [HtW-1:0]         ht_q, ht_d;
  logic [PosW-1:0]        pos_q, pos_d;
  logic [PosW-1:0]        cnt_q, cnt_d;
  logic [TapAw-1:0]       tap_q, tap_d;
  logic [TapAw-1:0]       head_q, head_d;
  logic [TapAw-1:0]       src_q, src_d;
  logic [SampleBits-1:0]  x_q, x_d;
  logic                   last_q, last_d;
  logic                   flush_q, flush_d;
  logic                   out_valid_q, out_valid_d;
  logic [SampleBits-1:0]  out_val_q, out_val_d;
  logic                   out_last_q, out_last_d;
  logic                   out_short_q, out_short_d;

  logic [SampleBits-1:0]  pre_mem [MaxHalfTaps+1];
  logic                   pre_we, pre_re;
  logic [HtW-1:0]         pre_waddr, pre_raddr;
  logic [SampleBits-1:0]  pre_rd_q;

  logic [SampleBits-1:0]  dly_mem [DlyDepth];
  logic                   dly_we, dly_re;
  logic [TapAw-1:0]       dly_waddr, dly_raddr;
  logic [SampleBits-1:0]  dly_wdata, dly_rd_q;

  mac_ctrl_t              mac_ctrl;
  logic                   mac_busy;
  logic [SampleBits-1:0]  mac_result;

  logic                   in_acc, slot_free;
  logic [PosW-1:0]        ht_ext, two_ht, cnt_inc;
  logic [HtW-1:0]         cfg_ht;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_acc      = in_i.valid & in_i.ready;
  assign slot_free   = !out_valid_q || out_o.ready;
  assign ht_ext      = {1'b0, ht_q};
  assign two_ht      = {ht_q, 1'b0};
  assign cnt_inc     = cnt_q + PosW'(1);

  // zero means one, and anything past the build maximum is clamped
  always_comb begin
    if (cfg_i.half_taps == '0) begin
      cfg_ht = HtW'(1);
    end else if (cfg_i.half_taps > HtW'(MaxHalfTaps)) begin
      cfg_ht = HtW'(MaxHalfTaps);
    end else begin
      cfg_ht = cfg_i.half_taps;
    end
  end

  always_comb begin
    state_d     = state_q;
    ht_d        = ht_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    tap_d       = tap_q;
    head_d      = head_q;
    src_d       = src_q;
    x_d         = x_q;
    last_d      = last_q;
    flush_d     = flush_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_val_d   = out_val_q;
    out_last_d  = out_last_q;
    out_short_d = out_short_q;
    pre_we      = 1'b0;
    pre_waddr   = pos_q[HtW-1:0];
    pre_re      = 1'b0;
    pre_raddr   = '0;
    dly_we      = 1'b0;
    dly_waddr   = head_q + TapAw'(1);
    dly_wdata   = x_q;
    dly_re      = 1'b0;
    dly_raddr   = head_q - tap_q;
    mac_ctrl    = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_i.operation == OP_LOAD) begin
            mac_ctrl.coef_we = (in_i.coef_index < TapAw'(TapDepth));
          end else begin
            x_d     = in_i.sample;
            last_d  = in_i.last_sample;
            flush_d = 1'b0;
            if (pos_q < ht_ext) begin
              pre_we = 1'b1;
              if (in_i.last_sample) begin
                state_d = ST_SHORT;
              end else begin
                pos_d = pos_q + PosW'(1);
              end
            end else if (pos_q == ht_ext) begin
              pre_we  = 1'b1;
              cnt_d   = '0;
              pos_d   = ht_ext + PosW'(1);
              state_d = ST_PRIME_RD;
            end else begin
              state_d = ST_PUSH;
            end
          end
        end
      end
      // mirrored prefix: held samples h down to 1, then 0 up to h-1
      ST_PRIME_RD: begin
        pre_re = 1'b1;
        if (cnt_q < ht_ext) begin
          pre_raddr = ht_q - cnt_q[HtW-1:0];
        end else begin
          pre_raddr = HtW'(cnt_q - ht_ext);
        end
        state_d = ST_PRIME_WR;
      end
      ST_PRIME_WR: begin
        dly_we    = 1'b1;
        dly_wdata = pre_rd_q;
        head_d    = head_q + TapAw'(1);
        cnt_d     = cnt_inc;
        state_d   = (cnt_inc == two_ht) ? ST_PUSH : ST_PRIME_RD;
      end
      ST_PUSH: begin
        dly_we         = 1'b1;
        head_d         = head_q + TapAw'(1);
        tap_d          = '0;
        mac_ctrl.clear = 1'b1;
        state_d        = ST_MAC;
      end
      ST_MAC: begin
        dly_re         = 1'b1;
        mac_ctrl.issue = 1'b1;
        tap_d          = tap_q + TapAw'(1);
        if (tap_q == TapAw'(two_ht)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!mac_busy) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_val_d   = mac_result;
          out_last_d  = flush_q && (cnt_inc == ht_ext);
          out_short_d = 1'b0;
          if (flush_q) begin
            if (cnt_inc == ht_ext) begin
              pos_d   = '0;
              state_d = ST_IDLE;
            end else begin
              cnt_d   = cnt_inc;
              state_d = ST_FLUSH_RD;
            end
          end else if (last_q) begin
            // mirrored tail starts one before the last sample
            flush_d = 1'b1;
            cnt_d   = '0;
            src_d   = head_q - TapAw'(1);
            state_d = ST_FLUSH_RD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_FLUSH_RD: begin
        dly_re    = 1'b1;
        dly_raddr = src_q;
        src_d     = src_q - TapAw'(1);
        state_d   = ST_FLUSH_LD;
      end
      ST_FLUSH_LD: begin
        x_d     = dly_rd_q;
        state_d = ST_PUSH;
      end
      ST_SHORT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_val_d   = '0;
          out_last_d  = 1'b1;
          out_short_d = 1'b1;
          pos_d       = '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // a new half length abandons the record in progress
    if (cfg_i.valid && cfg_i.ready) begin
      ht_d  = cfg_ht;
      pos_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ht_q        <= HtW'(1);
      pos_q       <= '0;
      cnt_q       <= '0;
      tap_q       <= '0;
      head_q      <= '0;
      src_q       <= '0;
      last_q      <= 1'b0;
      flush_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ht_q        <= ht_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      tap_q       <= tap_d;
      head_q      <= head_d;
      src_q       <= src_d;
      last_q      <= last_d;
      flush_q     <= flush_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q         <= x_d;
    out_val_q   <= out_val_d;
    out_last_q  <= out_last_d;
    out_short_q <= out_short_d;
  end

  always_ff @(posedge clk_i) begin
    if (pre_we) begin
      pre_mem[pre_waddr] <= in_i.sample;
    end
    if (pre_re) begin
      pre_rd_q <= pre_mem[pre_raddr];
    end
  end

  // circular delay line: the newest value sits at head_q
  always_ff @(posedge clk_i) begin
    if (dly_we) begin
      dly_mem[dly_waddr] <= dly_wdata;
    end
    if (dly_re) begin
      dly_rd_q <= dly_mem[dly_raddr];
    end
  end

  fmp_mac #(
    .SampleBits   (SampleBits),
    .CoefFracBits (CoefFracBits),
    .TapDepth     (TapDepth)
  ) u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (mac_ctrl),
    .coef_waddr_i (in_i.coef_index),
    .coef_wdata_i (signed'(in_i.coef_value)),
    .tap_i        (tap_q),
    .dly_rd_i     (signed'(dly_rd_q)),
    .busy_o       (mac_busy),
    .result_o     (mac_result)
  );

  assign out_o.valid          = out_valid_q;
  assign out_o.filtered_value = out_val_q;
  assign out_o.last_of_record = out_last_q;
  assign out_o.short_record   = out_short_q;

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= ht_ext + PosW'(1))
    else $error("position count beyond half length plus one");

  a_emit_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> !mac_busy)
    else $error("result taken before the mac drained");

  a_short_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.short_record |-> out_o.last_of_record && out_o.filtered_value == '0)
    else $error("short record beat malformed");

  a_prime_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PUSH && $past(state_q) == ST_PRIME_WR |-> pos_q == ht_ext + PosW'(1))
    else $error("priming ended outside the start of a record");

endmodule

`default_nettype wire

// ----- test/fir_filter_mirror_padded_checker.sv -----
// checker for the mirror-padded fir filter: follows the input, config and result channels,
// predicts every filtered value and compares it; needs fmp_pkg and the fmp_*_if interfaces
`timescale 1ns / 1ps

module fir_filter_mirror_padded_checker import fmp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  fmp_in_if    in_i,
  fmp_out_if   out_i,
  fmp_cfg_if   cfg_i,
  output int   errors_o,
  output int   pending_o,
  output int   results_o,
  output int   short_o
);

  localparam int TapDepth = 2 * MaxHalfTapsDef + 1;

  typedef struct {
    logic [15:0] value;
    logic        last;
    logic        short_rec;
  } filt_res_t;

  filt_res_t filtered_q[$];

  logic signed [17:0] coef_m [TapDepth];
  logic signed [15:0] taps_m [TapDepth];
  logic signed [15:0] head_m [64];
  logic signed [15:0] ring_m [64];
  int unsigned        ring_ptr;
  int unsigned        pos_cnt;
  int unsigned        half_m;

  assign pending_o = filtered_q.size();

  // shift one value into the delay line and return the rounded, saturated sum
  function automatic logic [15:0] mac_filter(logic signed [15:0] x);
    longint acc;
    longint q;
    int     n;
    n = 2 * half_m + 1;
    for (int i = n - 1; i > 0; i--) taps_m[i] = taps_m[i-1];
    taps_m[0] = x;
    acc = 0;
    for (int i = 0; i < n; i++) acc += longint'(coef_m[i]) * longint'(taps_m[i]);
    acc += longint'(1) << (CoefFracBitsDef - 1);
    q = acc >>> CoefFracBitsDef;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic void push_result(logic [15:0] v, logic last, logic shrt);
    filt_res_t r;
    r.value = v;
    r.last = last;
    r.short_rec = shrt;
    filtered_q.push_back(r);
  endfunction

  task automatic take_sample(logic signed [15:0] s, logic last);
    int unsigned p;
    int unsigned h;
    h = half_m;
    if (pos_cnt == 0) foreach (taps_m[i]) taps_m[i] = '0;
    ring_m[ring_ptr] = s;
    p = ring_ptr;
    ring_ptr = (ring_ptr + 1) % 64;
    if (pos_cnt <= h) begin
      head_m[pos_cnt % 64] = s;
      if (pos_cnt < h) begin
        if (last) begin
          push_result('0, 1'b1, 1'b1);
          pos_cnt = 0;
        end else begin
          pos_cnt++;
        end
        return;
      end
      // prime with the mirror image of the held samples
      for (int k = 0; k < h; k++) void'(mac_filter(head_m[(h - k) % 64]));
      for (int k = 0; k < h; k++) void'(mac_filter(head_m[k % 64]));
      pos_cnt = h + 1;
    end
    push_result(mac_filter(s), 1'b0, 1'b0);
    if (last) begin
      for (int k = 0; k < h; k++)
        push_result(mac_filter(ring_m[(p + 63 - k) % 64]), (k + 1 == h), 1'b0);
      pos_cnt = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    filt_res_t want;
    if (!rst_ni) begin
      foreach (coef_m[i]) coef_m[i] = '0;
      foreach (taps_m[i]) taps_m[i] = '0;
      foreach (head_m[i]) head_m[i] = '0;
      foreach (ring_m[i]) ring_m[i] = '0;
      ring_ptr = 0;
      pos_cnt = 0;
      half_m = 1;
      filtered_q.delete();
      errors_o <= 0;
      results_o <= 0;
      short_o <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        half_m = (cfg_i.half_taps == 0) ? 1 : cfg_i.half_taps;
        pos_cnt = 0;
      end
      if (in_i.valid && in_i.ready) begin
        if (op_e'(in_i.operation) == OP_LOAD) begin
          if (in_i.coef_index < TapDepth) coef_m[in_i.coef_index] = in_i.coef_value;
        end else begin
          take_sample(in_i.sample, in_i.last_sample);
        end
      end
      if (out_i.valid && out_i.ready) begin
        results_o <= results_o + 1;
        if (filtered_q.size() == 0) begin
          $error("result beat with nothing outstanding: value %0d", out_i.filtered_value);
          errors_o <= errors_o + 1;
        end else begin
          want = filtered_q.pop_front();
          if (want.short_rec) short_o <= short_o + 1;
          if (out_i.filtered_value !== want.value ||
              out_i.last_of_record !== want.last ||
              out_i.short_record !== want.short_rec)
            errors_o <= errors_o + 1;
          if (out_i.filtered_value !== want.value)
            $error("filtered_value: expected %0d, got %0d",
                   $signed(want.value), $signed(out_i.filtered_value));
          if (out_i.last_of_record !== want.last)
            $error("last_of_record: expected %0b, got %0b", want.last, out_i.last_of_record);
          if (out_i.short_record !== want.short_rec)
            $error("short_record: expected %0b, got %0b", want.short_rec, out_i.short_record);
        end
      end
    end
  end

endmodule

// ----- test/fir_filter_mirror_padded_test.sv -----
// testbench top for the mirror-padded fir filter: clock, reset, stimulus and verdict
// depends on fmp_pkg, the fmp_*_if interfaces, the filter and its checker
`timescale 1ns / 1ps

module fir_filter_mirror_padded_test import fmp_pkg::*;;

  localparam int StallLimit = 6000;
  localparam int SettleCycles = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   errors, pending, results, shorts;
  int   idle_cnt;
  int   items_sent;
  logic steady = 1'b0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;

  fmp_in_if  in_ch ();
  fmp_out_if out_ch ();
  fmp_cfg_if cfg_ch ();

  fir_filter_mirror_padded DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  fir_filter_mirror_padded_checker u_checker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_ch),
    .out_i    (out_ch),
    .cfg_i    (cfg_ch),
    .errors_o (errors),
    .pending_o(pending),
    .results_o(results),
    .short_o  (shorts)
  );

  always #5 clk_i = ~clk_i;

  // result side: random back-pressure, one long hold-off once a result waits
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done && out_ch.valid) begin
        out_ch.ready <= 1'b0;
        repeat (SettleCycles) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        out_ch.ready <= steady ? 1'b1 : ($urandom_range(99) >= 34);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= StallLimit) begin
      $display("timeout: no beat for %0d cycles", StallLimit);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_beat(logic op, logic [6:0] idx, logic [17:0] cv,
                           logic [15:0] smp, logic last);
    while (!steady && $urandom_range(99) < 34) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.coef_index <= idx;
    in_ch.coef_value <= cv;
    in_ch.sample <= smp;
    in_ch.last_sample <= last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic load_coef(int idx, int val);
    send_beat(OP_LOAD, idx[6:0], val[17:0], 16'($urandom), 1'($urandom));
  endtask

  task automatic send_sample(int val, logic last);
    send_beat(OP_SAMPLE, 7'($urandom), 18'($urandom), val[15:0], last);
  endtask

  // config writes only while the filter is drained
  task automatic set_half_taps(int h);
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.half_taps <= h[5:0];
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // fresh coefficients for every tap in use, scaled so most outputs stay in range
  task automatic load_taps(int h);
    int lim;
    lim = 131072 / (2 * h + 1);
    for (int i = 0; i < 2 * h + 1; i++) begin
      if ($urandom_range(19) == 0) load_coef(i, int'($signed(18'($urandom))));
      else load_coef(i, int'($urandom_range(2 * lim)) - lim);
    end
  endtask

  task automatic send_record(int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0)
        load_coef($urandom_range(126), int'($signed(18'($urandom))) >>> $urandom_range(6));
      send_sample(int'($signed(16'($urandom))), i == len - 1);
    end
  endtask

  task automatic random_phase(int h, int budget);
    int stop_at;
    int kind;
    stop_at = items_sent + budget;
    set_half_taps(h);
    load_taps(h);
    while (items_sent < stop_at) begin
      kind = $urandom_range(9);
      if (kind == 0) send_record($urandom_range(1, h));
      else if (kind == 1) send_record(h + 1);
      else send_record(h + 1 + $urandom_range(10));
    end
  endtask

  initial begin
    int phase_h[5] = '{2, 5, 3, 4, 7};
    idle_cnt = 0;
    items_sent = 0;
    in_ch.valid <= 1'b0;
    in_ch.operation <= OP_LOAD;
    in_ch.coef_index <= '0;
    in_ch.coef_value <= '0;
    in_ch.sample <= '0;
    in_ch.last_sample <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.half_taps <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero half length taken as one, coefficient extremes, saturation
    set_half_taps(0);
    load_coef(0, -131072);
    load_coef(1, 131071);
    load_coef(2, -131072);
    load_coef(127, 12345);
    send_sample(32767, 1'b0);
    send_sample(-32768, 1'b0);
    send_sample(32767, 1'b0);
    send_sample(-32768, 1'b1);
    send_sample(-32768, 1'b1);
    send_sample(0, 1'b0);
    send_sample(32767, 1'b1);
    load_coef(1, 65536);
    load_coef(0, 131071);
    send_sample(-1, 1'b0);
    send_sample(1, 1'b0);
    send_sample(-32768, 1'b1);

    // widest filter: exact minimum record and a short one
    set_half_taps(63);
    load_taps(63);
    send_record(64);
    send_record(5);

    foreach (phase_h[i]) begin
      if (i == 1) hold_req = 1'b1;
      steady = (i == 2);
      random_phase(phase_h[i], 15);
    end
    steady = 1'b0;

    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    $display("sent %0d items over half lengths 1..63, checked %0d results (%0d short records)",
             items_sent, results, shorts);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
